FILE: rtl/roab_pkg.sv
package roab_pkg;

  localparam int CoordW = 15;
  localparam int PixW   = 14;
  localparam int ChanW  = 8;
  localparam int ColorW = 32;
  localparam int IdxW   = 3;

  localparam logic [ChanW-1:0] ChanMax = 8'hFF;

  // Register indexes on the configuration port.
  localparam logic [IdxW-1:0] REG_RECT_LEFT     = 3'd0;
  localparam logic [IdxW-1:0] REG_RECT_TOP      = 3'd1;
  localparam logic [IdxW-1:0] REG_RECT_WIDTH    = 3'd2;
  localparam logic [IdxW-1:0] REG_RECT_HEIGHT   = 3'd3;
  localparam logic [IdxW-1:0] REG_OVERLAY_COLOR = 3'd4;
  localparam logic [IdxW-1:0] REG_FRAME_WIDTH   = 3'd5;
  localparam logic [IdxW-1:0] REG_FRAME_HEIGHT  = 3'd6;

  typedef struct packed {
    logic [CoordW-1:0] rect_left;
    logic [CoordW-1:0] rect_top;
    logic [CoordW-1:0] rect_width;
    logic [CoordW-1:0] rect_height;
    logic [ColorW-1:0] overlay_color;
    logic [CoordW-1:0] frame_width;
    logic [CoordW-1:0] frame_height;
  } cfg_t;

  typedef struct packed {
    logic [PixW-1:0]  x;
    logic [PixW-1:0]  y;
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] alpha;
  } pixel_t;

endpackage

FILE: rtl/roab_cfg_regs.sv
module roab_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [roab_pkg::IdxW-1:0]    cfg_index,
  input  logic [roab_pkg::ColorW-1:0]  cfg_wdata,
  output roab_pkg::cfg_t               cfg
);
  import roab_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_RECT_LEFT:     cfg_nxt.rect_left     = cfg_wdata[CoordW-1:0];
        REG_RECT_TOP:      cfg_nxt.rect_top      = cfg_wdata[CoordW-1:0];
        REG_RECT_WIDTH:    cfg_nxt.rect_width    = cfg_wdata[CoordW-1:0];
        REG_RECT_HEIGHT:   cfg_nxt.rect_height   = cfg_wdata[CoordW-1:0];
        REG_OVERLAY_COLOR: cfg_nxt.overlay_color = cfg_wdata;
        REG_FRAME_WIDTH:   cfg_nxt.frame_width   = cfg_wdata[CoordW-1:0];
        REG_FRAME_HEIGHT:  cfg_nxt.frame_height  = cfg_wdata[CoordW-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/roab_cover.sv
module roab_cover #(
  parameter int MAX_FRAME_DIM = 16384
) (
  input  roab_pkg::cfg_t                cfg,
  input  logic [roab_pkg::PixW-1:0]     x,
  input  logic [roab_pkg::PixW-1:0]     y,
  output logic                          hit
);
  import roab_pkg::*;

  localparam int LimW  = $clog2(MAX_FRAME_DIM + 1);
  localparam int ClipW = (LimW > CoordW) ? LimW : CoordW;
  localparam int SpanW = CoordW + 2;

  logic [ClipW-1:0] lim;
  logic [ClipW-1:0] fw_ext, fh_ext, fw_c, fh_c;
  logic signed [SpanW-1:0] px_s, py_s, left_s, top_s, right_s, bottom_s;
  logic x_in, y_in, sizes_ok;

  always_comb begin
    lim    = ClipW'(MAX_FRAME_DIM);
    fw_ext = ClipW'(cfg.frame_width);
    fh_ext = ClipW'(cfg.frame_height);
    fw_c   = (fw_ext > lim) ? lim : fw_ext;
    fh_c   = (fh_ext > lim) ? lim : fh_ext;

    px_s     = $signed({3'b000, x});
    py_s     = $signed({3'b000, y});
    left_s   = $signed({{2{cfg.rect_left[CoordW-1]}}, cfg.rect_left});
    top_s    = $signed({{2{cfg.rect_top[CoordW-1]}}, cfg.rect_top});
    right_s  = left_s + $signed({2'b00, cfg.rect_width});
    bottom_s = top_s + $signed({2'b00, cfg.rect_height});

    sizes_ok = (cfg.rect_width != '0) && (cfg.rect_height != '0) &&
               (fw_c != '0) && (fh_c != '0);
    x_in = (px_s >= left_s) && (px_s < right_s) && (ClipW'(x) < fw_c);
    y_in = (py_s >= top_s) && (py_s < bottom_s) && (ClipW'(y) < fh_c);
    hit  = sizes_ok && x_in && y_in;
  end

endmodule

FILE: rtl/roab_blend.sv
module roab_blend (
  input  logic [roab_pkg::ChanW-1:0] src,
  input  logic [roab_pkg::ChanW-1:0] dst,
  input  logic [roab_pkg::ChanW-1:0] a,
  output logic [roab_pkg::ChanW-1:0] res
);
  import roab_pkg::*;

  // src*a + dst*(255-a) is rewritten as dst*255 + (src-dst)*a, one multiplier.
  logic signed [ChanW:0]     diff;
  logic signed [2*ChanW+1:0] prod;
  logic signed [2*ChanW+1:0] base;
  logic signed [2*ChanW+1:0] sum;
  logic [2*ChanW-1:0]        num;
  logic [2*ChanW:0]          quo;

  always_comb begin
    diff = $signed({1'b0, src}) - $signed({1'b0, dst});
    prod = diff * $signed({1'b0, a});
    base = $signed({2'b00, dst, {ChanW{1'b0}}}) - $signed({{(ChanW+2){1'b0}}, dst});
    sum  = base + prod;
    num  = sum[2*ChanW-1:0];
    // Exact floor(num/255) for every numerator up to 255*255, which covers
    // the full range of the blend sum.
    quo  = {1'b0, num} + (2*ChanW+1)'(1) + (2*ChanW+1)'(num >> ChanW);
    res  = quo[2*ChanW-1:ChanW];
  end

endmodule

FILE: rtl/rect_overlay_alpha_blend_unit.sv
// Rectangle overlay compositor for RGBA8888 pixels. Each input transaction
// carries one destination pixel and its frame coordinates; each output
// transaction returns one pixel, in order. Pixels inside both the configured
// rectangle and the frame (clipped to MAX_FRAME_DIM) are blended source-over
// with the overlay color, and out_covered is set; all others pass through.
// The block takes one pixel per clock: a pixel is captured in the input
// register, where coverage and the three channel blends (one 9x8 multiplier
// each) are computed, and then sits in the output register until taken, so
// throughput is one transaction per cycle while out_ready stays high.
// Configuration registers are written through the cfg_ port and must only
// change while no transaction is in flight.
module rect_overlay_alpha_blend_unit #(
  parameter int MAX_FRAME_DIM = 16384
) (
  input  logic                         clk,
  input  logic                         rst_n,

  input  logic                         cfg_we,
  input  logic [roab_pkg::IdxW-1:0]    cfg_index,
  input  logic [roab_pkg::ColorW-1:0]  cfg_wdata,

  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [roab_pkg::PixW-1:0]    in_pixel_x,
  input  logic [roab_pkg::PixW-1:0]    in_pixel_y,
  input  logic [roab_pkg::ChanW-1:0]   in_dst_red,
  input  logic [roab_pkg::ChanW-1:0]   in_dst_green,
  input  logic [roab_pkg::ChanW-1:0]   in_dst_blue,
  input  logic [roab_pkg::ChanW-1:0]   in_dst_alpha,

  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [roab_pkg::ChanW-1:0]   out_red,
  output logic [roab_pkg::ChanW-1:0]   out_green,
  output logic [roab_pkg::ChanW-1:0]   out_blue,
  output logic [roab_pkg::ChanW-1:0]   out_alpha,
  output logic                         out_covered
);
  import roab_pkg::*;

  cfg_t cfg;

  roab_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Input register stage.
  logic   s1_valid_r;
  pixel_t s1_pix_r;
  logic   adv_out;
  logic   take_in;
  logic   out_valid_r;

  // The output register frees whenever it is empty or being drained, so the
  // input stage can move forward in the same cycle.
  assign adv_out  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || adv_out;
  assign take_in  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      s1_pix_r <= '{x: in_pixel_x, y: in_pixel_y, red: in_dst_red,
                    green: in_dst_green, blue: in_dst_blue, alpha: in_dst_alpha};
    end
  end

  // Coverage test and blend on the registered pixel.
  logic cover_hit;

  roab_cover #(.MAX_FRAME_DIM(MAX_FRAME_DIM)) u_cover (
    .cfg (cfg),
    .x   (s1_pix_r.x),
    .y   (s1_pix_r.y),
    .hit (cover_hit)
  );

  logic [ChanW-1:0] src_red, src_green, src_blue, src_alpha;
  logic [ChanW-1:0] mix_red, mix_green, mix_blue;
  logic [ChanW:0]   alpha_sum;
  logic [ChanW-1:0] alpha_sat;

  assign src_red   = cfg.overlay_color[31:24];
  assign src_green = cfg.overlay_color[23:16];
  assign src_blue  = cfg.overlay_color[15:8];
  assign src_alpha = cfg.overlay_color[7:0];

  roab_blend u_blend_red (
    .src (src_red),   .dst (s1_pix_r.red),   .a (src_alpha), .res (mix_red)
  );
  roab_blend u_blend_green (
    .src (src_green), .dst (s1_pix_r.green), .a (src_alpha), .res (mix_green)
  );
  roab_blend u_blend_blue (
    .src (src_blue),  .dst (s1_pix_r.blue),  .a (src_alpha), .res (mix_blue)
  );

  // Output alpha saturates at full opacity.
  assign alpha_sum = {1'b0, src_alpha} + {1'b0, s1_pix_r.alpha};
  assign alpha_sat = alpha_sum[ChanW] ? ChanMax : alpha_sum[ChanW-1:0];

  // Output register stage.
  logic [ChanW-1:0] out_red_r, out_green_r, out_blue_r, out_alpha_r;
  logic             out_covered_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv_out) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out && s1_valid_r) begin
      out_red_r     <= cover_hit ? mix_red   : s1_pix_r.red;
      out_green_r   <= cover_hit ? mix_green : s1_pix_r.green;
      out_blue_r    <= cover_hit ? mix_blue  : s1_pix_r.blue;
      out_alpha_r   <= cover_hit ? alpha_sat : s1_pix_r.alpha;
      out_covered_r <= cover_hit;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_red     = out_red_r;
  assign out_green   = out_green_r;
  assign out_blue    = out_blue_r;
  assign out_alpha   = out_alpha_r;
  assign out_covered = out_covered_r;

  // A pixel in the input stage moves to the output register when it frees.
  a_stage_advance: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && adv_out |=> out_valid_r)
    else $error("input stage transaction lost on advance");

  // The input side only stalls when both stages hold a transaction.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r && !out_ready))
    else $error("input stalled with a free stage");

  // A blended pixel never ends up less opaque than its destination.
  a_alpha_grows: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && adv_out && cover_hit |=> out_alpha_r >= $past(s1_pix_r.alpha))
    else $error("blended alpha below destination alpha");

  // An empty rectangle covers nothing.
  a_empty_rect: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && (cfg.rect_width == '0 || cfg.rect_height == '0) |-> !cover_hit)
    else $error("empty rectangle reported coverage");

endmodule
